[sv/dpp_pkg.sv]
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared widths, register codes, reset values and helpers for the depth pixel
// to point projection pipeline.
// ----------------------------------------------------------------------------
package dpp_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 12;
    localparam int RATIO_W    = 16;
    localparam int POINT_W    = 18;
    localparam int QUO_W      = 17;
    localparam int PROD_W     = 29;
    localparam int FRAC_SHIFT = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_RATIO      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RATIO      = 8'd3;

    localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 13'd480;
    localparam logic [RATIO_W-1:0] X_RATIO_RST      = 16'd18432;
    localparam logic [RATIO_W-1:0] Y_RATIO_RST      = 16'd13824;

    // One long-division stage for both axes, plus the fields riding along
    typedef struct packed {
        logic [DIM_W-1:0]   rem_x;
        logic [DIM_W-1:0]   rem_y;
        logic [QUO_W-1:0]   lo_x;
        logic [QUO_W-1:0]   lo_y;
        logic [QUO_W-1:0]   q_x;
        logic [QUO_W-1:0]   q_y;
        logic [DEPTH_W-1:0] depth;
        logic               err;
        logic               neg_x;
        logic               neg_y;
    } div_t;

    // Saturate a frame dimension to MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (d > lim) ? lim : d;
    endfunction

endpackage

[sv/dpp_in_if.sv]
// ----------------------------------------------------------------------------
// dpp_in_if
// Depth pixel channel: depth sample with its column and row.
// ----------------------------------------------------------------------------
interface dpp_in_if;
    logic                          valid;
    logic                          ready;
    logic [dpp_pkg::DEPTH_W-1:0]   depth_mm;
    logic [dpp_pkg::COORD_W-1:0]   column;
    logic [dpp_pkg::COORD_W-1:0]   row;

    modport source (output valid, depth_mm, column, row, input ready);
    modport sink   (input valid, depth_mm, column, row, output ready);
endinterface

[sv/dpp_out_if.sv]
// ----------------------------------------------------------------------------
// dpp_out_if
// Point channel: projected 3D point and coordinate error flag.
// ----------------------------------------------------------------------------
interface dpp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [dpp_pkg::POINT_W-1:0] point_x_mm;
    logic signed [dpp_pkg::POINT_W-1:0] point_y_mm;
    logic [dpp_pkg::DEPTH_W-1:0]        point_z_mm;
    logic                               coord_error;

    modport source (output valid, point_x_mm, point_y_mm, point_z_mm, coord_error,
                    input ready);
    modport sink   (input valid, point_x_mm, point_y_mm, point_z_mm, coord_error,
                    output ready);
endinterface

[sv/dpp_cfg_if.sv]
// ----------------------------------------------------------------------------
// dpp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dpp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dpp_pkg::CFG_IDX_W-1:0]    index;
    logic [dpp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/depth_to_point_projection_top.sv]
// ----------------------------------------------------------------------------
// depth_to_point_projection_top
// Projects a depth pixel to a 3D point through a multiply pipeline and a
// pipelined long division by the frame dimension.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  pixel   | in  | valid/ready  | depth_mm, column, row
//  point   | out | valid/ready  | point_x_mm, point_y_mm, point_z_mm, coord_error
//  cfg     | in  | valid/ready  | index, data (always ready)
//
//  One item per cycle sustained while the point sink is ready; 21 register
//  stages. The 17-stage restoring divider gives one quotient bit a stage.
//  The whole pipeline advances together; it holds only while a finished point
//  sits in the output register and the sink is not ready.
//  Reset (rst_n low, asynchronous) clears all valid bits and loads the
//  register defaults: 640 x 480, ratios 18432 and 13824.
// ----------------------------------------------------------------------------
module depth_to_point_projection_top (
    input  logic            clk,
    input  logic            rst_n,
    dpp_in_if.sink          pixel,
    dpp_out_if.source       point,
    dpp_cfg_if.sink         cfg
);

    localparam int NDIV = dpp_pkg::QUO_W + 1;

    // Configuration registers
    logic [dpp_pkg::DIM_W-1:0]   frame_width_reg;
    logic [dpp_pkg::DIM_W-1:0]   frame_height_reg;
    logic [dpp_pkg::RATIO_W-1:0] x_ratio_reg;
    logic [dpp_pkg::RATIO_W-1:0] y_ratio_reg;
    logic [dpp_pkg::DIM_W-1:0]   w_eff;
    logic [dpp_pkg::DIM_W-1:0]   h_eff;

    // Pipeline control
    logic                        advance;
    logic                        v0_reg;
    logic                        v1_reg;
    logic [NDIV-1:0]             dv_reg;
    logic                        out_valid_reg;

    // Stage 0: offsets and range check
    logic [dpp_pkg::DIM_W-1:0]   mag_x_next, mag_y_next;
    logic                        neg_x_next, neg_y_next, err_next;
    logic [dpp_pkg::DIM_W-1:0]   col2, row2;
    logic [dpp_pkg::DIM_W-1:0]   s0_mag_x_reg, s0_mag_y_reg;
    logic                        s0_neg_x_reg, s0_neg_y_reg, s0_err_reg;
    logic [dpp_pkg::DEPTH_W-1:0] s0_depth_reg;

    // Stage 1: offset times depth
    logic [dpp_pkg::PROD_W-1:0]  s1_px_reg, s1_py_reg;
    logic                        s1_neg_x_reg, s1_neg_y_reg, s1_err_reg;
    logic [dpp_pkg::DEPTH_W-1:0] s1_depth_reg;

    // Stage 2 and divider stages
    logic [dpp_pkg::PROD_W+dpp_pkg::RATIO_W-1:0] mx_full, my_full;
    logic [dpp_pkg::QUO_W+dpp_pkg::DIM_W-1:0]    mx, my;
    dpp_pkg::div_t               div_next [NDIV];
    dpp_pkg::div_t               div_reg  [NDIV];

    // Output stage
    logic signed [dpp_pkg::POINT_W-1:0] x_next, y_next;
    logic signed [dpp_pkg::POINT_W-1:0] x_reg, y_reg;
    logic [dpp_pkg::DEPTH_W-1:0] z_reg;
    logic                        err_reg;

    assign w_eff   = dpp_pkg::clamp_dim(frame_width_reg);
    assign h_eff   = dpp_pkg::clamp_dim(frame_height_reg);
    assign advance = !out_valid_reg || point.ready;

    assign pixel.ready = advance;
    assign cfg.ready   = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= dpp_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= dpp_pkg::FRAME_HEIGHT_RST;
            x_ratio_reg      <= dpp_pkg::X_RATIO_RST;
            y_ratio_reg      <= dpp_pkg::Y_RATIO_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dpp_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[dpp_pkg::DIM_W-1:0];
                dpp_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg.data[dpp_pkg::DIM_W-1:0];
                dpp_pkg::REG_X_RATIO:      x_ratio_reg      <= cfg.data;
                dpp_pkg::REG_Y_RATIO:      y_ratio_reg      <= cfg.data;
                default: ;
            endcase
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg        <= pixel.valid;
            v1_reg        <= v0_reg;
            dv_reg        <= {dv_reg[NDIV-2:0], v1_reg};
            out_valid_reg <= dv_reg[NDIV-1];
        end
    end

    // Stage 0: signed offsets from frame center, range check
    always_comb
    begin
        col2       = {pixel.column, 1'b0};
        row2       = {pixel.row, 1'b0};
        neg_x_next = w_eff > col2;
        mag_x_next = neg_x_next ? (w_eff - col2) : (col2 - w_eff);
        neg_y_next = row2 > h_eff;
        mag_y_next = neg_y_next ? (row2 - h_eff) : (h_eff - row2);
        err_next   = ({1'b0, pixel.column} >= w_eff) || ({1'b0, pixel.row} >= h_eff);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_mag_x_reg <= mag_x_next;
            s0_mag_y_reg <= mag_y_next;
            s0_neg_x_reg <= neg_x_next;
            s0_neg_y_reg <= neg_y_next;
            s0_err_reg   <= err_next;
            s0_depth_reg <= pixel.depth_mm;
        end
    end

    // Stage 1: offset times depth
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_px_reg    <= s0_mag_x_reg * s0_depth_reg;
            s1_py_reg    <= s0_mag_y_reg * s0_depth_reg;
            s1_neg_x_reg <= s0_neg_x_reg;
            s1_neg_y_reg <= s0_neg_y_reg;
            s1_err_reg   <= s0_err_reg;
            s1_depth_reg <= s0_depth_reg;
        end
    end

    // Stage 2: times ratio, drop the 2^15 part of the divisor
    always_comb
    begin
        mx_full = s1_px_reg * x_ratio_reg;
        my_full = s1_py_reg * y_ratio_reg;
        mx      = mx_full[dpp_pkg::FRAC_SHIFT +: dpp_pkg::QUO_W+dpp_pkg::DIM_W];
        my      = my_full[dpp_pkg::FRAC_SHIFT +: dpp_pkg::QUO_W+dpp_pkg::DIM_W];
        div_next[0].rem_x = mx[dpp_pkg::QUO_W +: dpp_pkg::DIM_W];
        div_next[0].rem_y = my[dpp_pkg::QUO_W +: dpp_pkg::DIM_W];
        div_next[0].lo_x  = mx[dpp_pkg::QUO_W-1:0];
        div_next[0].lo_y  = my[dpp_pkg::QUO_W-1:0];
        div_next[0].q_x   = '0;
        div_next[0].q_y   = '0;
        div_next[0].depth = s1_depth_reg;
        div_next[0].err   = s1_err_reg;
        div_next[0].neg_x = s1_neg_x_reg;
        div_next[0].neg_y = s1_neg_y_reg;
    end

    // Divider: one quotient bit per stage for each axis
    for (genvar k = 0; k < dpp_pkg::QUO_W; k++)
    begin : g_div
        logic [dpp_pkg::DIM_W:0] tx, ty, dx, dy;
        logic                    gex, gey;

        always_comb
        begin
            tx  = {div_reg[k].rem_x, div_reg[k].lo_x[dpp_pkg::QUO_W-1-k]};
            ty  = {div_reg[k].rem_y, div_reg[k].lo_y[dpp_pkg::QUO_W-1-k]};
            gex = tx >= {1'b0, w_eff};
            gey = ty >= {1'b0, h_eff};
            dx  = tx - {1'b0, w_eff};
            dy  = ty - {1'b0, h_eff};
            div_next[k+1]       = div_reg[k];
            div_next[k+1].rem_x = gex ? dx[dpp_pkg::DIM_W-1:0] : tx[dpp_pkg::DIM_W-1:0];
            div_next[k+1].rem_y = gey ? dy[dpp_pkg::DIM_W-1:0] : ty[dpp_pkg::DIM_W-1:0];
            div_next[k+1].q_x   = {div_reg[k].q_x[dpp_pkg::QUO_W-2:0], gex};
            div_next[k+1].q_y   = {div_reg[k].q_y[dpp_pkg::QUO_W-2:0], gey};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NDIV; i++)
            begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // Output stage: apply sign, zero the point on a coordinate error
    always_comb
    begin
        x_next = {1'b0, div_reg[NDIV-1].q_x};
        y_next = {1'b0, div_reg[NDIV-1].q_y};
        if (div_reg[NDIV-1].neg_x)
        begin
            x_next = -x_next;
        end
        if (div_reg[NDIV-1].neg_y)
        begin
            y_next = -y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg   <= div_reg[NDIV-1].err ? '0 : x_next;
            y_reg   <= div_reg[NDIV-1].err ? '0 : y_next;
            z_reg   <= div_reg[NDIV-1].err ? '0 : div_reg[NDIV-1].depth;
            err_reg <= div_reg[NDIV-1].err;
        end
    end

    assign point.valid       = out_valid_reg;
    assign point.point_x_mm  = x_reg;
    assign point.point_y_mm  = y_reg;
    assign point.point_z_mm  = z_reg;
    assign point.coord_error = err_reg;

`ifndef SYNTHESIS
    // An accepted item occupies the first stage on the next cycle
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> v0_reg)
        else $error("accepted item missing from first stage");

    // A stall freezes every valid bit in the pipeline
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(dv_reg) && $stable(v0_reg) && $stable(v1_reg)))
        else $error("pipeline moved during stall");

    // An error point is all zeros
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg) |-> (x_reg == '0 && y_reg == '0 && z_reg == '0))
        else $error("error point not zeroed");

    // Zero depth projects to the origin
    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && z_reg == '0) |-> (x_reg == '0 && y_reg == '0))
        else $error("zero depth gave nonzero X or Y");
`endif

endmodule

[bench/depth_to_point_projection_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_to_point_projection_checker
// Watches the pixel, point and configuration channels, computes the expected
// 3D point for every accepted pixel and compares it with the produced point.
// ----------------------------------------------------------------------------
module depth_to_point_projection_checker (
    input  logic      clk,
    input  logic      rst_n,
    dpp_in_if         pixel,
    dpp_out_if        point,
    dpp_cfg_if        cfg,
    output int        fail_count,
    output int        pending_points
);

    typedef struct packed {
        logic signed [dpp_pkg::POINT_W-1:0] x;
        logic signed [dpp_pkg::POINT_W-1:0] y;
        logic [dpp_pkg::DEPTH_W-1:0]        z;
        logic                               err;
    } point_t;

    logic [dpp_pkg::DIM_W-1:0]   width_q;
    logic [dpp_pkg::DIM_W-1:0]   height_q;
    logic [dpp_pkg::RATIO_W-1:0] xr_q;
    logic [dpp_pkg::RATIO_W-1:0] yr_q;
    point_t                      expected_points[$];

    // Truncating projection of one axis: (a - b) * depth * ratio / (dim * 32768)
    function automatic logic [dpp_pkg::POINT_W-1:0] axis_mm(longint a, longint b,
                                                            longint depth, longint ratio,
                                                            longint dim);
        longint mag;
        longint q;
        mag = (a > b) ? a - b : b - a;
        q   = (mag * depth * ratio) / (dim * 32768);
        if (b > a)
            q = -q;
        return q[dpp_pkg::POINT_W-1:0];
    endfunction

    function automatic point_t project_pixel(logic [dpp_pkg::DEPTH_W-1:0] d,
                                             logic [dpp_pkg::COORD_W-1:0] c,
                                             logic [dpp_pkg::COORD_W-1:0] r);
        point_t p;
        longint w;
        longint h;
        w = (width_q > dpp_pkg::MAX_DIM) ? dpp_pkg::MAX_DIM : width_q;
        h = (height_q > dpp_pkg::MAX_DIM) ? dpp_pkg::MAX_DIM : height_q;
        if (c >= w || r >= h) begin
            p = '0;
            p.err = 1'b1;
        end
        else begin
            p.x   = axis_mm(2 * longint'(c), w, d, xr_q, w);
            p.y   = axis_mm(h, 2 * longint'(r), d, yr_q, h);
            p.z   = d;
            p.err = 1'b0;
        end
        return p;
    endfunction

    assign pending_points = expected_points.size();

    // Track registers, queue predictions, compare points
    always @(posedge clk or negedge rst_n)
    begin
        point_t e;
        if (!rst_n) begin
            width_q    <= dpp_pkg::FRAME_WIDTH_RST;
            height_q   <= dpp_pkg::FRAME_HEIGHT_RST;
            xr_q       <= dpp_pkg::X_RATIO_RST;
            yr_q       <= dpp_pkg::Y_RATIO_RST;
            fail_count <= 0;
            expected_points.delete();
        end
        else begin
            if (pixel.valid && pixel.ready)
                expected_points.push_back(project_pixel(pixel.depth_mm, pixel.column,
                                                        pixel.row));
            if (point.valid && point.ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point x=%0d y=%0d z=%0d err=%0b", $time,
                             point.point_x_mm, point.point_y_mm, point.point_z_mm,
                             point.coord_error);
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_points.pop_front();
                    if (e.x !== point.point_x_mm || e.y !== point.point_y_mm ||
                        e.z !== point.point_z_mm || e.err !== point.coord_error) begin
                        $display("%0t: point mismatch expected x=%0d y=%0d z=%0d err=%0b",
                                 $time, e.x, e.y, e.z, e.err);
                        $display("%0t:                  actual x=%0d y=%0d z=%0d err=%0b",
                                 $time, point.point_x_mm, point.point_y_mm,
                                 point.point_z_mm, point.coord_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    dpp_pkg::REG_FRAME_WIDTH:  width_q  <= cfg.data[dpp_pkg::DIM_W-1:0];
                    dpp_pkg::REG_FRAME_HEIGHT: height_q <= cfg.data[dpp_pkg::DIM_W-1:0];
                    dpp_pkg::REG_X_RATIO:      xr_q     <= cfg.data;
                    dpp_pkg::REG_Y_RATIO:      yr_q     <= cfg.data;
                    default: ;
                endcase
            end
        end
    end
endmodule

[bench/depth_to_point_projection_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_to_point_projection_top_test
// Drives depth pixels through several frame and ratio settings with random
// gaps and output stalls; the checker predicts and compares every point.
// ----------------------------------------------------------------------------
module depth_to_point_projection_top_test;

    typedef logic [dpp_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [dpp_pkg::CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [dpp_pkg::DEPTH_W-1:0]    depth_t;
    typedef logic [dpp_pkg::COORD_W-1:0]    coord_t;

    localparam int  LATENCY     = 21;
    localparam longint MAX_CYCLES = 400000;
    // Index past the register list; a write there is ignored
    localparam cfg_idx_t REG_UNUSED = 8'd9;

    logic   clk;
    logic   rst_n;
    int     fail_count;
    int     pending_points;
    longint cycle_count;
    int     stall_mode;

    dpp_in_if  pixel ();
    dpp_out_if point ();
    dpp_cfg_if cfg ();

    depth_to_point_projection_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .point (point),
        .cfg   (cfg)
    );

    depth_to_point_projection_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel          (pixel),
        .point          (point),
        .cfg            (cfg),
        .fail_count     (fail_count),
        .pending_points (pending_points)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 30);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Stall the point channel at random; stall_mode 0 means never
    always @(negedge clk)
    begin
        int n;
        if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
            n = gap_len();
            if (n > 0) begin
                point.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
        end
        point.ready <= 1'b1;
    end

    // Present one register write; the caller drops valid after the last one
    task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_frame(int w, int h, int xr, int yr);
        write_reg(dpp_pkg::REG_FRAME_WIDTH, cfg_data_t'(w));
        write_reg(dpp_pkg::REG_FRAME_HEIGHT, cfg_data_t'(h));
        write_reg(dpp_pkg::REG_X_RATIO, cfg_data_t'(xr));
        write_reg(dpp_pkg::REG_Y_RATIO, cfg_data_t'(yr));
        write_reg(REG_UNUSED, cfg_data_t'($urandom));
        cfg.valid <= 1'b0;
    endtask

    // Send one pixel, optionally after a random gap
    task automatic send_pixel(int d, int c, int r, bit gaps);
        int n;
        if (gaps) begin
            n = gap_len();
            if (n > 0) begin
                pixel.valid <= 1'b0;
                repeat (n) @(negedge clk);
            end
        end
        pixel.valid    <= 1'b1;
        pixel.depth_mm <= depth_t'(d);
        pixel.column   <= coord_t'(c);
        pixel.row      <= coord_t'(r);
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        pixel.valid <= 1'b0;
        while (pending_points != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Random pixels: mostly inside the frame, some anywhere
    task automatic random_phase(int count, int w, int h);
        int wl;
        int hl;
        bit gaps;
        wl = (w > dpp_pkg::MAX_DIM) ? dpp_pkg::MAX_DIM : w;
        hl = (h > dpp_pkg::MAX_DIM) ? dpp_pkg::MAX_DIM : h;
        gaps = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                gaps = ($urandom_range(0, 3) != 0);
            if (wl > 0 && hl > 0 && $urandom_range(0, 9) != 0)
                send_pixel($urandom_range(0, 65535), $urandom_range(0, wl - 1),
                           $urandom_range(0, hl - 1), gaps);
            else
                send_pixel($urandom_range(0, 65535), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), gaps);
        end
    endtask

    initial
    begin
        int w;
        int h;
        rst_n          = 1'b0;
        cycle_count    = 0;
        stall_mode     = 0;
        pixel.valid    = 1'b0;
        pixel.depth_mm = '0;
        pixel.column   = '0;
        pixel.row      = '0;
        point.ready    = 1'b1;
        cfg.valid      = 1'b0;
        cfg.index      = '0;
        cfg.data       = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, extremes and out-of-frame cases
        send_pixel(0, 0, 0, 0);
        send_pixel(65535, 0, 0, 0);
        send_pixel(65535, 639, 479, 0);
        send_pixel(1234, 320, 240, 0);
        send_pixel(65535, 640, 0, 0);
        send_pixel(65535, 0, 480, 0);
        send_pixel(500, 4095, 4095, 0);
        drain();
        set_frame(4096, 4096, 65535, 65535);
        send_pixel(65535, 0, 0, 0);
        send_pixel(65535, 4095, 4095, 0);
        send_pixel(65535, 2048, 2048, 0);
        send_pixel(65535, 2047, 1, 0);
        drain();
        set_frame(8191, 5000, 0, 65535);
        send_pixel(65535, 4095, 0, 0);
        send_pixel(40000, 100, 4095, 0);
        drain();
        set_frame(0, 10, 100, 100);
        send_pixel(1000, 0, 0, 0);
        drain();
        set_frame(1, 1, 65535, 65535);
        send_pixel(65535, 0, 0, 0);
        send_pixel(65535, 1, 0, 0);
        send_pixel(65535, 0, 1, 0);
        drain();
        set_frame(7, 0, 65535, 1);
        send_pixel(65535, 3, 0, 0);
        drain();

        // Random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 4;
            case (ph)
                0: begin w = 640; h = 480; end
                1: begin w = 4096; h = 4096; end
                2: begin w = 1; h = 4096; end
                3: begin w = 8191; h = 1; end
                default: begin w = $urandom_range(1, 8191); h = $urandom_range(1, 8191); end
            endcase
            set_frame(w, h, (ph == 1) ? 65535 : $urandom_range(0, 65535),
                      (ph == 2) ? 0 : $urandom_range(0, 65535));
            random_phase(180, w, h);
            drain();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
